[hdl/pkfq_pkg.sv]
// ----------------------------------------------------------------------------
// pkfq_pkg
// Shared types and constants of the per-key FIFO queue manager.
// ----------------------------------------------------------------------------
package pkfq_pkg;

    localparam int NUM_KEYS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int ID_BITS_DEF     = 16;

    localparam int REQ_W  = 3;
    localparam int RID_W  = 16;
    localparam int KEY_W  = 4;
    localparam int STAT_W = 2;
    localparam int POS_W  = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ    = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_DEQ    = 3'd2,
        REQ_POS    = 3'd3,
        REQ_PEEK   = 3'd4,
        REQ_PEEKANY = 3'd5
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_DUP   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_EXEC = 2'd2,
        S_OUT  = 2'd3
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [RID_W-1:0] id;
        logic [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [RID_W-1:0]  rid;
        logic [KEY_W-1:0]  key;
        logic [POS_W-1:0]  pos;
        logic              key_has;
        logic              any;
    } t_res;

endpackage

[hdl/pkfq_ram.sv]
// ----------------------------------------------------------------------------
// pkfq_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module pkfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/pkfq_front.sv]
// ----------------------------------------------------------------------------
// pkfq_front
// Request intake: two-entry queue that decouples the stream from the engine.
// ----------------------------------------------------------------------------
module pkfq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pkfq_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output pkfq_pkg::t_cmd o_cmd
);
    pkfq_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

[hdl/pkfq_back.sv]
// ----------------------------------------------------------------------------
// pkfq_back
// Queue engine: read one key's row, compare entries in parallel, write back.
// ----------------------------------------------------------------------------
module pkfq_back #(
    parameter int NUM_KEYS    = pkfq_pkg::NUM_KEYS_DEF,
    parameter int QUEUE_DEPTH = pkfq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = pkfq_pkg::ID_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pkfq_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output pkfq_pkg::t_res o_res
);
    localparam int KA = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = QUEUE_DEPTH * ID_BITS;
    localparam int SW = (ID_BITS < pkfq_pkg::RID_W) ? ID_BITS : pkfq_pkg::RID_W;

    pkfq_pkg::t_state r_state, n_state;
    pkfq_pkg::t_cmd   r_cmd;
    pkfq_pkg::t_res   r_res, n_res;
    logic [CW-1:0]    r_cnt [NUM_KEYS];
    logic [ID_BITS-1:0] r_front [NUM_KEYS];
    logic [NUM_KEYS-1:0] w_nz;
    logic [KA-1:0]    w_first;

    logic          w_valid_key, w_we, w_ram_we, w_take, w_cnt_we;
    logic [KA-1:0] w_key;
    logic [RW-1:0] w_row, n_row;
    logic [CW-1:0] w_cnt, n_cnt;
    logic [ID_BITS-1:0] w_id, w_front, w_any_front, w_e;
    logic [QUEUE_DEPTH-1:0] w_hit, w_hit_new;
    logic [PW-1:0] w_pos, w_pos_new;
    logic          w_found;
    logic [NUM_KEYS-1:0] w_nz_new;

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) w_nz[k] = (r_cnt[k] != '0);
    end

    always_comb begin
        w_first = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (w_nz[k]) w_first = KA'(k);
        end
    end

    assign w_valid_key = ({{(32-pkfq_pkg::KEY_W){1'b0}}, r_cmd.key} < NUM_KEYS);
    assign w_key   = KA'(r_cmd.key);
    assign w_cnt   = w_valid_key ? r_cnt[w_key] : '0;
    assign w_id    = ID_BITS'(r_cmd.id[SW-1:0]);
    assign w_front = w_row[ID_BITS-1:0];
    assign w_any_front = r_front[w_first];
    assign w_take  = i_valid && o_ready;
    assign w_ram_we = w_we && (r_state == pkfq_pkg::S_EXEC);

    pkfq_ram #(.WIDTH(RW), .DEPTH(NUM_KEYS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_key),
        .i_wdata(n_row),
        .i_raddr(w_key),
        .o_rdata(w_row)
    );

    always_comb begin
        w_hit = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_hit[i] = (i < w_cnt) && (w_row[i*ID_BITS +: ID_BITS] == w_id);
        end
        w_pos = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (w_hit[i]) w_pos = PW'(i + 1);
        end
        w_found = |w_hit;
    end

    always_comb begin
        n_row    = w_row;
        n_cnt    = w_cnt;
        w_we     = 1'b0;
        w_cnt_we = 1'b0;
        n_res         = '0;
        n_res.key     = r_cmd.key;
        case (r_cmd.req)
            pkfq_pkg::REQ_ENQ: begin
                if (!w_valid_key) n_res.status = pkfq_pkg::ST_EMPTY;
                else if (w_found) n_res.status = pkfq_pkg::ST_DUP;
                else if (w_cnt >= CW'(QUEUE_DEPTH)) n_res.status = pkfq_pkg::ST_FULL;
                else begin
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        if (i == w_cnt) n_row[i*ID_BITS +: ID_BITS] = w_id;
                    end
                    n_cnt = w_cnt + 1'b1; w_we = 1'b1; w_cnt_we = 1'b1;
                end
            end
            pkfq_pkg::REQ_REMOVE, pkfq_pkg::REQ_DEQ: begin
                if (w_cnt == '0) n_res.status = pkfq_pkg::ST_EMPTY;
                else if (r_cmd.req == pkfq_pkg::REQ_DEQ || w_found) begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        if (r_cmd.req == pkfq_pkg::REQ_DEQ || i + 1 >= w_pos) begin
                            n_row[i*ID_BITS +: ID_BITS] = w_row[(i+1)*ID_BITS +: ID_BITS];
                        end
                    end
                    if (r_cmd.req == pkfq_pkg::REQ_DEQ)
                        n_res.rid = pkfq_pkg::RID_W'(w_front[SW-1:0]);
                    n_cnt = w_cnt - 1'b1; w_we = 1'b1; w_cnt_we = 1'b1;
                end
            end
            pkfq_pkg::REQ_PEEK: begin
                if (w_cnt == '0) n_res.status = pkfq_pkg::ST_EMPTY;
                else n_res.rid = pkfq_pkg::RID_W'(w_front[SW-1:0]);
            end
            pkfq_pkg::REQ_PEEKANY: begin
                if (w_nz == '0) n_res.status = pkfq_pkg::ST_EMPTY;
                else begin
                    n_res.rid = pkfq_pkg::RID_W'(w_any_front[SW-1:0]);
                    n_res.key = pkfq_pkg::KEY_W'(w_first);
                end
            end
            default: ;
        endcase
        // position after the update, against the new row
        w_hit_new = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_e = n_row[i*ID_BITS +: ID_BITS];
            w_hit_new[i] = (i < n_cnt) && (w_e == w_id);
        end
        w_pos_new = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (w_hit_new[i]) w_pos_new = PW'(i + 1);
        end
        n_res.pos     = pkfq_pkg::POS_W'(w_pos_new);
        n_res.key_has = w_valid_key && (n_cnt != '0);
        w_nz_new = w_nz;
        if (w_valid_key) w_nz_new[w_key] = (n_cnt != '0);
        n_res.any = |w_nz_new;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pkfq_pkg::S_IDLE: if (w_take) n_state = pkfq_pkg::S_READ;
            pkfq_pkg::S_READ: n_state = pkfq_pkg::S_EXEC;
            pkfq_pkg::S_EXEC: n_state = pkfq_pkg::S_OUT;
            pkfq_pkg::S_OUT: begin
                if (i_ready) n_state = w_take ? pkfq_pkg::S_READ : pkfq_pkg::S_IDLE;
            end
            default: n_state = pkfq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == pkfq_pkg::S_IDLE) ||
                  ((r_state == pkfq_pkg::S_OUT) && i_ready);
        o_valid = (r_state == pkfq_pkg::S_OUT);
        o_res   = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_cmd <= i_cmd;
        if (r_state == pkfq_pkg::S_EXEC) r_res <= n_res;
        if (w_ram_we) r_front[w_key] <= n_row[ID_BITS-1:0];
        if (!i_rst_n) begin
            r_state <= pkfq_pkg::S_IDLE;
            for (int k = 0; k < NUM_KEYS; k++) r_cnt[k] <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == pkfq_pkg::S_EXEC) && w_cnt_we) r_cnt[w_key] <= n_cnt;
        end
    end
endmodule

[hdl/per_key_fifo_queue_manager.sv]
// ----------------------------------------------------------------------------
// per_key_fifo_queue_manager
// One FIFO of requester IDs per key, with enqueue, remove, dequeue, position,
// peek and peek-any requests, one result per request.
// ----------------------------------------------------------------------------
// Each request passes through the engine states row read, compare and
// write-back, and result out, and the result then waits in the output register
// until taken; the next request enters the engine in the cycle its
// predecessor's result is taken, so the engine works on one request at a
// time, its pace set by the registered read of the row memory ahead of the
// compare. A two-entry intake queue lets the input side accept up to two
// requests while the engine works.
module per_key_fifo_queue_manager #(
    parameter int NUM_KEYS    = pkfq_pkg::NUM_KEYS_DEF,
    parameter int QUEUE_DEPTH = pkfq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = pkfq_pkg::ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // requester_id[15:0], key_index[19:16]
    input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // requester_out, key_out, position,
                                       // key_has_entries, any_entries, pad
    output logic [1:0]  m_axis_tuser   // status[1:0]
);
    pkfq_pkg::t_cmd w_in_cmd, w_q_cmd;
    pkfq_pkg::t_res w_res;
    logic           w_q_valid, w_q_ready;

    assign w_in_cmd.req = s_axis_tuser;
    assign w_in_cmd.id  = s_axis_tdata[15:0];
    assign w_in_cmd.key = s_axis_tdata[19:16];

    pkfq_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_cmd  (w_in_cmd),
        .o_valid(w_q_valid),
        .i_ready(w_q_ready),
        .o_cmd  (w_q_cmd)
    );

    pkfq_back #(
        .NUM_KEYS(NUM_KEYS), .QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_q_valid),
        .o_ready(w_q_ready),
        .i_cmd  (w_q_cmd),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_res  (w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.any, w_res.key_has, w_res.pos, w_res.key, w_res.rid};
    assign m_axis_tuser = w_res.status;

    a_empty_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[25] |-> !m_axis_tdata[24])
        else $error("key has entries while table empty");
    a_pos_has: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[23:20] != 4'd0) |-> m_axis_tdata[24])
        else $error("position reported in empty queue");
    a_full_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == pkfq_pkg::ST_DUP) |-> m_axis_tdata[23:20] != 4'd0)
        else $error("duplicate without position");
endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Per-key FIFO queue manager testbench
// Drives enqueue, remove, dequeue, position, peek and peek-any requests through
// the input stream. An in-bench model of the key queues predicts each result,
// and every result item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NKEYS  = 16;
    localparam int DEPTH  = 8;
    localparam int LIMIT  = 400000;
    localparam int PRED_N = 64;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] rid;
        logic [3:0]  key;
        logic [3:0]  pos;
        logic        key_has;
        logic        any;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    logic [15:0] row_ids [NKEYS][DEPTH];
    int          row_len [NKEYS];
    t_result     pred_fifo [PRED_N];
    int          pred_wr = 0;
    int          pred_rd = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;

    per_key_fifo_queue_manager dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int locate(int k, logic [15:0] id);
        for (int i = 0; i < row_len[k]; i++)
            if (row_ids[k][i] == id) return i + 1;
        return 0;
    endfunction

    function automatic void pop_at(int k, int i);
        for (int j = i; j + 1 < row_len[k]; j++) row_ids[k][j] = row_ids[k][j+1];
        row_len[k]--;
    endfunction

    function automatic t_result predict_queue_op(logic [2:0] op, logic [15:0] id,
                                                 logic [3:0] key);
        t_result r;
        int k;
        int p;
        k = key;
        r.status = pkfq_pkg::ST_OK;
        r.rid = '0;
        r.key = key;
        r.any = 1'b0;
        case (op)
            pkfq_pkg::REQ_ENQ: begin
                if (locate(k, id) != 0) r.status = pkfq_pkg::ST_DUP;
                else if (row_len[k] >= DEPTH) r.status = pkfq_pkg::ST_FULL;
                else begin
                    row_ids[k][row_len[k]] = id;
                    row_len[k]++;
                end
            end
            pkfq_pkg::REQ_REMOVE: begin
                if (row_len[k] == 0) r.status = pkfq_pkg::ST_EMPTY;
                else begin
                    p = locate(k, id);
                    if (p != 0) pop_at(k, p - 1);
                end
            end
            pkfq_pkg::REQ_DEQ, pkfq_pkg::REQ_PEEK: begin
                if (row_len[k] == 0) r.status = pkfq_pkg::ST_EMPTY;
                else begin
                    r.rid = row_ids[k][0];
                    if (op == pkfq_pkg::REQ_DEQ) pop_at(k, 0);
                end
            end
            pkfq_pkg::REQ_PEEKANY: begin
                r.status = pkfq_pkg::ST_EMPTY;
                for (int i = NKEYS - 1; i >= 0; i--)
                    if (row_len[i] != 0) begin
                        r.status = pkfq_pkg::ST_OK;
                        r.key = 4'(i);
                        r.rid = row_ids[i][0];
                    end
            end
            default: ;
        endcase
        r.pos = 4'(locate(k, id));
        r.key_has = row_len[k] != 0;
        for (int i = 0; i < NKEYS; i++) if (row_len[i] != 0) r.any = 1'b1;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what,
                 got, want);
        error_count++;
    endtask

    // Receiver: alternate windows of steady acceptance and random stalls, check each taken item.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pred_wr == pred_rd) begin
                    report("unexpected item", m_axis_tdata, 32'd0);
                end else begin
                    e = pred_fifo[pred_rd % PRED_N];
                    pred_rd++;
                    if (m_axis_tuser != e.status)
                        report("status", 32'(m_axis_tuser), 32'(e.status));
                    if (m_axis_tdata[15:0] != e.rid)
                        report("requester_out", 32'(m_axis_tdata[15:0]), 32'(e.rid));
                    if (m_axis_tdata[19:16] != e.key)
                        report("key_out", 32'(m_axis_tdata[19:16]), 32'(e.key));
                    if (m_axis_tdata[23:20] != e.pos)
                        report("position", 32'(m_axis_tdata[23:20]), 32'(e.pos));
                    if (m_axis_tdata[24] != e.key_has)
                        report("key_has_entries", 32'(m_axis_tdata[24]), 32'(e.key_has));
                    if (m_axis_tdata[25] != e.any)
                        report("any_entries", 32'(m_axis_tdata[25]), 32'(e.any));
                end
            end
            if ((cycle_count / 400) % 3 == 0) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_item(logic [2:0] op, logic [15:0] id, logic [3:0] key);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {4'd0, key, id};
        do @(posedge i_clk); while (!s_axis_tready);
        pred_fifo[pred_wr % PRED_N] = predict_queue_op(op, id, key);
        pred_wr++;
        if (burst_left == 0) s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        if (burst_left != 0) s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pred_wr != pred_rd) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_item(pkfq_pkg::REQ_DEQ, 16'h0000, 4'd0);
        send_item(pkfq_pkg::REQ_PEEK, 16'hFFFF, 4'd15);
        send_item(pkfq_pkg::REQ_PEEKANY, 16'h1234, 4'd7);
        send_item(pkfq_pkg::REQ_REMOVE, 16'h0001, 4'd3);
        send_item(pkfq_pkg::REQ_POS, 16'hFFFF, 4'd9);
        send_item(3'd6, 16'hAAAA, 4'd1);
        send_item(3'd7, 16'h5555, 4'd14);
    endtask

    task automatic test_fill_and_drain();
        for (int i = 0; i < 9; i++) send_item(pkfq_pkg::REQ_ENQ, 16'(16'hFFF0 + i), 4'd15);
        send_item(pkfq_pkg::REQ_ENQ, 16'hFFF3, 4'd15);
        send_item(pkfq_pkg::REQ_POS, 16'hFFF7, 4'd15);
        send_item(pkfq_pkg::REQ_REMOVE, 16'hFFF3, 4'd15);
        send_item(pkfq_pkg::REQ_REMOVE, 16'h0000, 4'd15);
        send_item(pkfq_pkg::REQ_PEEKANY, 16'h0000, 4'd0);
        send_item(pkfq_pkg::REQ_PEEK, 16'h0000, 4'd15);
        send_item(pkfq_pkg::REQ_DEQ, 16'hFFF1, 4'd15);
        drain_results();
    endtask

    task automatic test_random(int n);
        logic [2:0] op;
        logic [3:0] key;
        logic [15:0] id;
        for (int i = 0; i < n; i++) begin
            key = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0) id = 16'($urandom);
            else id = 16'($urandom_range(0, 11)) ^ {16{key[0]}};
            op = $urandom_range(0, 9) == 0 ? 3'($urandom) :
                 ($urandom_range(0, 2) == 0 ? pkfq_pkg::REQ_ENQ :
                                              3'($urandom_range(0, 5)));
            send_item(op, id, key);
            if (i == n / 2) drain_results();
        end
    endtask

    initial begin
        for (int k = 0; k < NKEYS; k++) row_len[k] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_fill_and_drain();
        test_random(1330);
        drain_results();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
